// ===== rtl/bchd_pkg.sv =====
// ----------------------------------------------------------------------------
// bchd_pkg
// shared types, codes and defaults of the button click and hold detector
// ----------------------------------------------------------------------------
package bchd_pkg;

   localparam int NUM_BUTTONS_DEF = 3;
   localparam int TIMER_BITS_DEF  = 16;
   localparam int NUM_PINS        = 3;

   localparam int CFG_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int EV_W    = 3;
   localparam int KEY_W   = 3;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_PRESS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLICK_GAP  = 2'd2;

   localparam logic [CFG_W-1:0] MIN_PRESS_RST  = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;
   localparam logic [CFG_W-1:0] CLICK_GAP_RST  = 16'd300;

   localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
   localparam logic [EV_W-1:0] EV_HOLD     = 3'd1;
   localparam logic [EV_W-1:0] EV_SINGLE   = 3'd2;
   localparam logic [EV_W-1:0] EV_DOUBLE   = 3'd3;
   localparam logic [EV_W-1:0] EV_TRIPLE   = 3'd4;
   localparam logic [EV_W-1:0] EV_RELEASED = 3'd5;

   localparam logic [KEY_W-1:0] KEY_NONE   = 3'd0;
   localparam logic [KEY_W-1:0] KEY_UP     = 3'd1;
   localparam logic [KEY_W-1:0] KEY_DOWN   = 3'd2;
   localparam logic [KEY_W-1:0] KEY_SELECT = 3'd3;
   localparam logic [KEY_W-1:0] KEY_RETURN = 3'd4;

   typedef struct packed {
      logic [CFG_W-1:0] min_press_ms;
      logic [CFG_W-1:0] long_press_ms;
      logic [CFG_W-1:0] click_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_code;
      logic [EV_W-1:0]  up_event;
      logic [EV_W-1:0]  select_event;
      logic [EV_W-1:0]  down_event;
   } result_type;

endpackage

// ===== rtl/bchd_lane.sv =====
// ----------------------------------------------------------------------------
// bchd_lane
// per-button press timer, click counter and gap timer with event decode
// ----------------------------------------------------------------------------
module bchd_lane #(
   parameter int TIMER_BITS = bchd_pkg::TIMER_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       level,
   input  bchd_pkg::cfg_type          cfg,
   output logic [bchd_pkg::EV_W-1:0]  lane_event
);
   import bchd_pkg::*;

   localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_PRESSED = 2'd1;
   localparam logic [1:0] PH_GAP     = 2'd2;

   localparam logic [3:0] COUNT_MAX = 4'd15;

   logic [1:0]            phase_ff, phase_in;
   logic                  hold_ff, hold_in;
   logic [TIMER_BITS-1:0] press_ff, press_in;
   logic [TIMER_BITS-1:0] gap_ff, gap_in;
   logic [3:0]            count_ff, count_in;

   logic [TIMER_BITS-1:0] press_inc, gap_inc;
   logic                  ge_min, ge_long, ge_gap;

   always_comb begin
      press_inc = (press_ff == '1) ? press_ff : press_ff + TIMER_BITS'(1);
      gap_inc   = (gap_ff == '1) ? gap_ff : gap_ff + TIMER_BITS'(1);
      ge_min    = CW'(press_inc) >= CW'(cfg.min_press_ms);
      ge_long   = CW'(press_inc) >= CW'(cfg.long_press_ms);
      ge_gap    = CW'(gap_inc) >= CW'(cfg.click_gap_ms);
   end

   always_comb begin
      phase_in   = phase_ff;
      hold_in    = hold_ff;
      press_in   = press_ff;
      gap_in     = gap_ff;
      count_in   = count_ff;
      lane_event = EV_NONE;
      if (phase_ff == PH_PRESSED) begin
         press_in = press_inc;
         if (!level) begin
            if (ge_long) begin
               lane_event = EV_HOLD;
               hold_in    = 1'b1;
            end
         end else if (hold_ff) begin
            lane_event = EV_RELEASED;
            count_in   = '0;
            hold_in    = 1'b0;
            phase_in   = PH_IDLE;
         end else begin
            if (ge_min && !ge_long && count_ff != COUNT_MAX) begin
               count_in = count_ff + 4'd1;
            end
            gap_in   = '0;
            phase_in = PH_GAP;
         end
      end else if (!level) begin
         press_in = '0;
         phase_in = PH_PRESSED;
      end else if (phase_ff == PH_GAP) begin
         gap_in = gap_inc;
         if (ge_gap) begin
            case (count_ff)
               4'd1: lane_event = EV_SINGLE;
               4'd2: lane_event = EV_DOUBLE;
               4'd3: lane_event = EV_TRIPLE;
               default: lane_event = EV_NONE;
            endcase
            count_in = '0;
            phase_in = PH_IDLE;
         end
      end else begin
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hold_ff  <= 1'b0;
         press_ff <= '0;
         gap_ff   <= '0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
         press_ff <= press_in;
         gap_ff   <= gap_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/bchd_merge.sv =====
// ----------------------------------------------------------------------------
// bchd_merge
// priority merge of the lane events into a key code and a result word
// ----------------------------------------------------------------------------
module bchd_merge (
   input  logic [bchd_pkg::EV_W-1:0] up_event,
   input  logic [bchd_pkg::EV_W-1:0] select_event,
   input  logic [bchd_pkg::EV_W-1:0] down_event,
   output bchd_pkg::result_type      result
);
   import bchd_pkg::*;

   logic [KEY_W-1:0] key;

   always_comb begin
      key = KEY_NONE;
      if (up_event == EV_SINGLE) begin
         key = KEY_UP;
      end
      if (select_event == EV_HOLD) begin
         key = KEY_RETURN;
      end else if (select_event == EV_SINGLE) begin
         key = KEY_SELECT;
      end
      if (down_event == EV_SINGLE) begin
         key = KEY_DOWN;
      end
      result.key_code     = key;
      result.up_event     = up_event;
      result.select_event = select_event;
      result.down_event   = down_event;
   end

endmodule

// ===== rtl/button_click_hold_detector_unit.sv =====
// ----------------------------------------------------------------------------
// button_click_hold_detector_unit
// multi-click and long-press detector for up, select and down buttons
// ----------------------------------------------------------------------------
// usage:
//   one req_ transfer per millisecond tick carries the active-low pin levels
//   of the three buttons; every tick gives exactly one rsp_ transfer with a
//   key code and the event of each button.
//   csr_ writes set the press, long-press and gap times in ticks; write them
//   while no result is pending.
// output and throughput:
//   the result of a tick is registered into the output buffer; one tick per
//   cycle is taken while req_ready is high.
//   a two-entry output buffer lets a new tick enter while a result waits.
// reset:
//   all lanes idle with counters cleared, registers back to 50, 500 and 300,
//   output buffer empty.
// stall:
//   while rsp_ready is low the buffer fills; once both entries are full
//   req_ready drops until the receiver takes a result.
// ----------------------------------------------------------------------------
module button_click_hold_detector_unit #(
   parameter int NUM_BUTTONS = bchd_pkg::NUM_BUTTONS_DEF,
   parameter int TIMER_BITS  = bchd_pkg::TIMER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_up_level,
   input  logic                              req_select_level,
   input  logic                              req_down_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bchd_pkg::KEY_W-1:0]        rsp_key_code,
   output logic [bchd_pkg::EV_W-1:0]         rsp_up_event,
   output logic [bchd_pkg::EV_W-1:0]         rsp_select_event,
   output logic [bchd_pkg::EV_W-1:0]         rsp_down_event,
   input  logic                              csr_write_enable,
   input  logic [bchd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bchd_pkg::CFG_W-1:0]        csr_write_data
);
   import bchd_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_press_ms  <= MIN_PRESS_RST;
         cfg_ff.long_press_ms <= LONG_PRESS_RST;
         cfg_ff.click_gap_ms  <= CLICK_GAP_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MIN_PRESS:  cfg_ff.min_press_ms  <= csr_write_data;
            REG_LONG_PRESS: cfg_ff.long_press_ms <= csr_write_data;
            REG_CLICK_GAP:  cfg_ff.click_gap_ms  <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic                push, pop;
   logic [NUM_PINS-1:0] pins;
   logic [EV_W-1:0]     lane_ev [NUM_BUTTONS];
   logic [EV_W-1:0]     pin_ev  [NUM_PINS];

   assign push = req_valid && req_ready;
   assign pop  = rsp_valid && rsp_ready;
   assign pins = {req_down_level, req_select_level, req_up_level};

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic lvl;
      if (i < NUM_PINS) begin : g_pin
         assign lvl = pins[i];
      end else begin : g_idle
         assign lvl = 1'b1;
      end
      bchd_lane #(
         .TIMER_BITS (TIMER_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .step       (push),
         .level      (lvl),
         .cfg        (cfg_ff),
         .lane_event (lane_ev[i])
      );
   end

   for (genvar j = 0; j < NUM_PINS; j++) begin : g_pin_ev
      if (j < NUM_BUTTONS) begin : g_used
         assign pin_ev[j] = lane_ev[j];
      end else begin : g_none
         assign pin_ev[j] = EV_NONE;
      end
   end

   result_type merged;

   bchd_merge u_merge (
      .up_event     (pin_ev[0]),
      .select_event (pin_ev[1]),
      .down_event   (pin_ev[2]),
      .result       (merged)
   );

   // output register with skid entry
   result_type main_ff, skid_ff;
   logic       main_valid_ff, skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (!main_valid_ff) begin
         main_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else begin
            main_ff <= merged;
         end
      end else if (!main_valid_ff) begin
         main_ff <= merged;
      end else if (push) begin
         skid_ff <= merged;
      end
   end

   assign req_ready        = !skid_valid_ff;
   assign rsp_valid        = main_valid_ff;
   assign rsp_key_code     = main_ff.key_code;
   assign rsp_up_event     = main_ff.up_event;
   assign rsp_select_event = main_ff.select_event;
   assign rsp_down_event   = main_ff.down_event;

endmodule

// ===== dv/button_click_hold_detector_unit_test.sv =====
// ----------------------------------------------------------------------------
// button_click_hold_detector_unit_test
// self-checking testbench for the three-button click and hold detector
//
// Pin-level ticks are sent over the request channel, and every response is
// compared field by field against an in-bench model of the lanes. The model
// covers press timing, click counting, hold and release reports, the
// gap-closed click events and the key-code merge. Named tests cover the reset
// timing, short directed sequences, counter saturation and extreme timing
// registers. Random press/release sequences are then timed around each
// setting. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module button_click_hold_detector_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bchd_pkg::*;

   localparam int CLOCK_HALF  = 6;
   localparam int STALL_LIMIT = 4000;
   localparam logic [TIMER_BITS_DEF-1:0] TIMER_TOP = '1;
   localparam logic [3:0] CLICKS_TOP = 4'd15;

   typedef enum logic [1:0] {LANE_IDLE, LANE_PRESSED, LANE_GAP} lane_phase_e;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_up_level;
   logic                 req_select_level;
   logic                 req_down_level;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [KEY_W-1:0]     rsp_key_code;
   logic [EV_W-1:0]      rsp_up_event;
   logic [EV_W-1:0]      rsp_select_event;
   logic [EV_W-1:0]      rsp_down_event;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_write_data;

   // lane model
   lane_phase_e               lane_phase [3];
   bit                        lane_held [3];
   logic [TIMER_BITS_DEF-1:0] lane_press_time [3];
   logic [TIMER_BITS_DEF-1:0] lane_quiet_time [3];
   logic [3:0]                lane_clicks [3];
   logic [CFG_W-1:0]          model_min;
   logic [CFG_W-1:0]          model_long;
   logic [CFG_W-1:0]          model_gap;

   result_type predicted_results [$];

   // stimulus side copy of the timing registers
   int tm_min  = MIN_PRESS_RST;
   int tm_long = LONG_PRESS_RST;
   int tm_gap  = CLICK_GAP_RST;

   int  run_left [3] = '{0, 0, 0};
   bit  run_level [3] = '{1'b1, 1'b1, 1'b1};
   bit  idle_off = 1'b0;

   int mismatches      = 0;
   int ticks_sent      = 0;
   int results_checked = 0;
   int timing_settings = 1;
   int clicks_seen     = 0;
   int holds_seen      = 0;
   int releases_seen   = 0;

   button_click_hold_detector_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_up_level     (req_up_level),
      .req_select_level (req_select_level),
      .req_down_level   (req_down_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_code     (rsp_key_code),
      .rsp_up_event     (rsp_up_event),
      .rsp_select_event (rsp_select_event),
      .rsp_down_event   (rsp_down_event),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic void clear_model();
      for (int l = 0; l < 3; l++) begin
         lane_phase[l]      = LANE_IDLE;
         lane_held[l]       = 1'b0;
         lane_press_time[l] = '0;
         lane_quiet_time[l] = '0;
         lane_clicks[l]     = '0;
      end
      model_min  = MIN_PRESS_RST;
      model_long = LONG_PRESS_RST;
      model_gap  = CLICK_GAP_RST;
   endfunction

   function automatic logic [TIMER_BITS_DEF-1:0] timer_step(
      logic [TIMER_BITS_DEF-1:0] t
   );
      return (t == TIMER_TOP) ? t : t + 1'b1;
   endfunction

   function automatic logic [EV_W-1:0] lane_update(int l, logic level);
      logic [EV_W-1:0] ev;
      ev = EV_NONE;
      if (lane_phase[l] == LANE_PRESSED) begin
         lane_press_time[l] = timer_step(lane_press_time[l]);
         if (!level) begin
            if (lane_press_time[l] >= model_long) begin
               ev = EV_HOLD;
               lane_held[l] = 1'b1;
            end
         end else if (lane_held[l]) begin
            ev = EV_RELEASED;
            lane_clicks[l] = '0;
            lane_held[l]   = 1'b0;
            lane_phase[l]  = LANE_IDLE;
         end else begin
            if (lane_press_time[l] >= model_min && lane_press_time[l] < model_long &&
                lane_clicks[l] != CLICKS_TOP)
               lane_clicks[l] = lane_clicks[l] + 1'b1;
            lane_quiet_time[l] = '0;
            lane_phase[l]      = LANE_GAP;
         end
      end else if (!level) begin
         lane_press_time[l] = '0;
         lane_phase[l]      = LANE_PRESSED;
      end else if (lane_phase[l] == LANE_GAP) begin
         lane_quiet_time[l] = timer_step(lane_quiet_time[l]);
         if (lane_quiet_time[l] >= model_gap) begin
            case (lane_clicks[l])
               4'd1: ev = EV_SINGLE;
               4'd2: ev = EV_DOUBLE;
               4'd3: ev = EV_TRIPLE;
               default: ev = EV_NONE;
            endcase
            lane_clicks[l] = '0;
            lane_phase[l]  = LANE_IDLE;
         end
      end else begin
         lane_phase[l] = LANE_IDLE;
      end
      return ev;
   endfunction

   function automatic result_type predict_tick(logic up, logic sel, logic dn);
      result_type r;
      r.up_event     = lane_update(0, up);
      r.select_event = lane_update(1, sel);
      r.down_event   = lane_update(2, dn);
      r.key_code     = KEY_NONE;
      if (r.up_event == EV_SINGLE) r.key_code = KEY_UP;
      if (r.select_event == EV_HOLD) r.key_code = KEY_RETURN;
      else if (r.select_event == EV_SINGLE) r.key_code = KEY_SELECT;
      if (r.down_event == EV_SINGLE) r.key_code = KEY_DOWN;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < 50) $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s expected %0d got %0d",
                                   results_checked, name, want, got));
   endtask

   task automatic tally_event(logic [EV_W-1:0] ev);
      if (ev == EV_SINGLE || ev == EV_DOUBLE || ev == EV_TRIPLE) clicks_seen++;
      if (ev == EV_HOLD) holds_seen++;
      if (ev == EV_RELEASED) releases_seen++;
   endtask

   // tick and register tracking, response checking
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_model();
         predicted_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_MIN_PRESS:  model_min  = csr_write_data;
               REG_LONG_PRESS: model_long = csr_write_data;
               REG_CLICK_GAP:  model_gap  = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predicted_results.push_back(
               predict_tick(req_up_level, req_select_level, req_down_level));
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (predicted_results.size() == 0) begin
               report_mismatch($sformatf("result with no tick pending, key %0d",
                                         rsp_key_code));
            end else begin
               want = predicted_results.pop_front();
               check_field("key_code", want.key_code, rsp_key_code);
               check_field("up_event", want.up_event, rsp_up_event);
               check_field("select_event", want.select_event, rsp_select_event);
               check_field("down_event", want.down_event, rsp_down_event);
            end
            tally_event(rsp_up_event);
            tally_event(rsp_select_event);
            tally_event(rsp_down_event);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (idle_off || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // response side back-pressure
   initial begin
      int run;
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(20, 120);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // ends the run when no transfer or register write happens for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             csr_write_enable)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_tick(bit up, bit sel, bit dn);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_up_level     <= up;
      req_select_level <= sel;
      req_down_level   <= dn;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic send_levels(bit up, bit sel, bit dn, int n);
      repeat (n) send_tick(up, sel, dn);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CFG_W'(value);
      @(posedge clock);
   endtask

   task automatic set_timing(int min_press, int long_press, int click_gap);
      wait_drained();
      write_reg(REG_MIN_PRESS, min_press);
      write_reg(REG_LONG_PRESS, long_press);
      write_reg(REG_CLICK_GAP, click_gap);
      csr_write_enable <= 1'b0;
      tm_min  = min_press;
      tm_long = long_press;
      tm_gap  = click_gap;
      timing_settings++;
   endtask

   // press or release run length, placed around the current thresholds
   function automatic int pick_run(bit pressing);
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (pressing) begin
         if (r < 10) len = $urandom_range(1, 3);
         else if (r < 30) len = (tm_min > 1) ? $urandom_range(1, tm_min - 1) : 1;
         else if (r < 80)
            len = (tm_long > tm_min + 1) ? $urandom_range(tm_min, tm_long - 1) : tm_min + 1;
         else len = tm_long + $urandom_range(0, 4);
      end else begin
         if (r < 15) len = $urandom_range(1, 2);
         else if (r < 70) len = (tm_gap > 1) ? $urandom_range(1, tm_gap) : 1;
         else len = tm_gap + 1 + $urandom_range(0, 3);
      end
      if (len < 1) len = 1;
      if (len > 60) len = 60;
      return len;
   endfunction

   task automatic random_ticks(int n);
      repeat (n) begin
         for (int l = 0; l < 3; l++) begin
            if (run_left[l] == 0) begin
               run_level[l] = ~run_level[l];
               run_left[l]  = pick_run(!run_level[l]);
            end
            run_left[l]--;
         end
         send_tick(run_level[0], run_level[1], run_level[2]);
      end
   endtask

   task automatic test_reset_timing();
      send_levels(1'b0, 1'b1, 1'b0, 20);
      send_levels(1'b0, 1'b1, 1'b1, 40);
      send_levels(1'b1, 1'b1, 1'b1, 300);
      send_levels(1'b1, 1'b0, 1'b1, 505);
      send_levels(1'b1, 1'b1, 1'b1, 2);
   endtask

   task automatic test_directed_events();
      set_timing(2, 4, 2);
      send_levels(1'b0, 1'b1, 1'b1, 3);
      send_levels(1'b1, 1'b1, 1'b1, 3);
      send_levels(1'b1, 1'b0, 1'b1, 6);
      send_levels(1'b1, 1'b1, 1'b1, 1);
      send_levels(1'b0, 1'b0, 1'b0, 2);
      send_levels(1'b1, 1'b1, 1'b1, 3);
      // up triple, select single, down double with a too-short third press
      send_levels(1'b0, 1'b0, 1'b0, 2);
      send_levels(1'b1, 1'b1, 1'b1, 1);
      send_levels(1'b0, 1'b1, 1'b0, 2);
      send_levels(1'b1, 1'b1, 1'b1, 1);
      send_levels(1'b0, 1'b1, 1'b1, 2);
      send_levels(1'b1, 1'b1, 1'b0, 1);
      send_levels(1'b1, 1'b1, 1'b1, 3);
   endtask

   task automatic test_click_saturation();
      set_timing(0, 8, 40);
      for (int n = 0; n < 36; n++)
         send_tick(n % 2 != 0, (n % 2 != 0) || n >= 8, (n % 2 != 0) || n >= 6);
      send_levels(1'b1, 1'b1, 1'b1, 45);
   endtask

   task automatic test_register_extremes();
      int corners [6][3] = '{'{0, 0, 1}, '{0, 0, 0}, '{65535, 65535, 65535},
                            '{65535, 1, 0}, '{1, 65535, 1}, '{0, 1, 65535}};
      foreach (corners[k]) begin
         set_timing(corners[k][0], corners[k][1], corners[k][2]);
         random_ticks(20);
      end
   endtask

   task automatic test_random_sequences();
      int lo;
      for (int phase = 0; phase < 6; phase++) begin
         lo = $urandom_range(0, 6);
         set_timing(lo, $urandom_range(1, 12), $urandom_range(1, 10));
         idle_off = (phase % 3 == 0);
         random_ticks(60);
      end
      idle_off = 1'b0;
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_up_level     <= 1'b1;
      req_select_level <= 1'b1;
      req_down_level   <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_MIN_PRESS;
      csr_write_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_timing();
      test_directed_events();
      test_click_saturation();
      test_register_extremes();
      test_random_sequences();

      wait_drained();
      repeat (4) @(posedge clock);
      $display("covered %0d ticks over %0d timing settings, %0d responses checked",
               ticks_sent, timing_settings, results_checked);
      $display("lane events seen: %0d click reports, %0d hold reports, %0d releases",
               clicks_seen, holds_seen, releases_seen);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
